/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by every file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an overlapping implication on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Check that a condition leads to a property in the following cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

/* hw/rtl/tlut_pkg.sv */
package tlut_pkg;

   localparam int ADC_W     = 12;
   localparam int TEMP_W    = 15;
   localparam int ROM_ROWS  = 34;
   localparam int ROM_IDX_W = 6;
   localparam int DEN_W     = 8;   // widest breakpoint gap is 220
   localparam int DY_W      = 9;   // temperature step per row
   localparam int NUM_W     = DEN_W + DY_W;
   localparam int CNT_W     = $clog2(NUM_W);

   localparam int TEMP_BASE = -2500;
   localparam int TEMP_STEP = 500;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SEARCH,
      ST_MULT,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      RES_INTERP,
      RES_COLD,
      RES_SHORT
   } result_sel_type;

   typedef struct packed {
      logic           load;
      logic           step;
      logic           mult;
      logic           divide;
      logic           write_rsp;
      result_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic below_last;
      logic above_first;
      logic hit;
      logic div_last;
      logic rsp_free;
   } status_type;

   // Falling ADC breakpoints, coldest row first.
   function automatic logic [ADC_W-1:0] rom_adc(input logic [ROM_IDX_W-1:0] idx);
      logic [ADC_W-1:0] v;
      case (idx)
         6'd0:  v = 12'd4088;  6'd1:  v = 12'd3974;  6'd2:  v = 12'd3841;
         6'd3:  v = 12'd3687;  6'd4:  v = 12'd3515;  6'd5:  v = 12'd3326;
         6'd6:  v = 12'd3122;  6'd7:  v = 12'd2908;  6'd8:  v = 12'd2689;
         6'd9:  v = 12'd2469;  6'd10: v = 12'd2252;  6'd11: v = 12'd2042;
         6'd12: v = 12'd1842;  6'd13: v = 12'd1655;  6'd14: v = 12'd1482;
         6'd15: v = 12'd1323;  6'd16: v = 12'd1179;  6'd17: v = 12'd1049;
         6'd18: v = 12'd933;   6'd19: v = 12'd830;   6'd20: v = 12'd739;
         6'd21: v = 12'd658;   6'd22: v = 12'd586;   6'd23: v = 12'd523;
         6'd24: v = 12'd467;   6'd25: v = 12'd418;   6'd26: v = 12'd375;
         6'd27: v = 12'd337;   6'd28: v = 12'd303;   6'd29: v = 12'd273;
         6'd30: v = 12'd246;   6'd31: v = 12'd223;   6'd32: v = 12'd202;
         6'd33: v = 12'd184;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Row temperatures rise by one step per row from the coldest point.
   function automatic logic signed [TEMP_W-1:0] rom_temp(input logic [ROM_IDX_W-1:0] idx);
      return TEMP_W'(TEMP_BASE + TEMP_STEP * int'(idx));
   endfunction

endpackage

/* hw/rtl/tlut_ctrl.sv */
module tlut_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tlut_pkg::status_type status,
   output tlut_pkg::cmd_type    cmd
);
   import tlut_pkg::*;

   state_type      state_ff, state_in;
   result_sel_type sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (status.below_last) begin
               sel_in   = RES_SHORT;
               state_in = ST_WRITE;
            end else if (status.above_first) begin
               sel_in   = RES_COLD;
               state_in = ST_WRITE;
            end else begin
               sel_in   = RES_INTERP;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.hit) state_in = ST_MULT;
         end
         ST_MULT: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.sel       = sel_ff;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SEARCH: cmd.step      = 1'b1;
         ST_MULT:   cmd.mult      = 1'b1;
         ST_DIVIDE: cmd.divide    = 1'b1;
         ST_WRITE:  cmd.write_rsp = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      sel_ff <= sel_in;
   end

endmodule

/* hw/rtl/tlut_dpath.sv */
module tlut_dpath #(
   parameter int ROWS = 34
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tlut_pkg::ADC_W-1:0]        req_raw_sample,
   input  tlut_pkg::cmd_type                 cmd,
   output tlut_pkg::status_type              status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tlut_pkg::TEMP_W-1:0] rsp_temp_centideg,
   output logic                              rsp_temp_valid
);
   import tlut_pkg::*;

   localparam logic [ROM_IDX_W-1:0] LAST_IDX = ROM_IDX_W'(ROWS - 1);

   logic [ADC_W-1:0]         sample_ff, sample_in;
   logic [ROM_IDX_W-1:0]     idx_ff, idx_in;
   logic signed [TEMP_W-1:0] base_ff, base_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [NUM_W-1:0]         quot_ff, quot_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;

   logic [ROM_IDX_W-1:0]     prev_idx;
   logic [ADC_W-1:0]         x0, x1, gap_x;
   logic [TEMP_W-1:0]        dy;
   logic [DEN_W:0]           shifted, trial;
   logic signed [TEMP_W-1:0] interp;

   assign prev_idx = idx_ff - ROM_IDX_W'(1);
   assign x0       = rom_adc(prev_idx);
   assign x1       = rom_adc(idx_ff);
   assign gap_x    = x0 - sample_ff;
   assign dy       = rom_temp(idx_ff) - rom_temp(prev_idx);
   assign shifted  = {rem_ff, quot_ff[NUM_W-1]};
   assign trial    = shifted - {1'b0, den_ff};
   assign interp   = base_ff + $signed({1'b0, quot_ff[TEMP_W-2:0]});

   assign status.below_last  = sample_ff <= rom_adc(LAST_IDX);
   assign status.above_first = sample_ff > rom_adc('0);
   assign status.hit         = sample_ff > x1;
   assign status.div_last    = cnt_ff == CNT_W'(NUM_W - 1);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sample_in     = sample_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      cnt_in        = cnt_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         sample_in = req_raw_sample;
         idx_in    = ROM_IDX_W'(1);
      end
      if (cmd.step && !status.hit) idx_in = idx_ff + ROM_IDX_W'(1);
      if (cmd.mult) begin
         quot_in = gap_x[DEN_W-1:0] * dy[DY_W-1:0];
         den_in  = x0[DEN_W-1:0] - x1[DEN_W-1:0];
         base_in = rom_temp(prev_idx);
         rem_in  = '0;
         cnt_in  = '0;
      end
      if (cmd.divide) begin
         if (!trial[DEN_W]) begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.write_rsp) begin
         rsp_valid_in = 1'b1;
         case (cmd.sel)
            RES_SHORT: begin
               rsp_temp_in   = '0;
               rsp_tvalid_in = 1'b0;
            end
            RES_COLD: begin
               rsp_temp_in   = rom_temp('0);
               rsp_tvalid_in = 1'b1;
            end
            default: begin
               rsp_temp_in   = interp;
               rsp_tvalid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      sample_ff     <= sample_in;
      idx_ff        <= idx_in;
      base_ff       <= base_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      cnt_ff        <= cnt_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_tvalid_ff <= rsp_tvalid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temp_centideg = rsp_temp_ff;
   assign rsp_temp_valid    = rsp_tvalid_ff;

endmodule

/* hw/rtl/thermistor_lut_interpolator_top.sv */
// Flow: a shorted sensor or a sample beyond the coldest point goes from acceptance
// straight to the result write; any other sample scans rows up from row 1, at most to
// the last row in use, then multiplies and divides. Throughput: one transaction at a
// time; the linear row scan and the 17-step restoring divider must finish first.
// Reset: synchronous, active high; idles the controller and drops any pending result.
module thermistor_lut_interpolator_top #(
   parameter int TABLE_ENTRIES = 34
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tlut_pkg::ADC_W-1:0]         req_raw_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tlut_pkg::TEMP_W-1:0] rsp_temp_centideg,
   output logic                               rsp_temp_valid
);
   import tlut_pkg::*;

   `include "assert_macros.svh"

   // Clamp the rows in use to what the ROM holds, and never fewer than two.
   localparam int ROWS = (TABLE_ENTRIES > ROM_ROWS) ? ROM_ROWS :
                         (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;

   cmd_type    cmd;
   status_type status;

   // Controller: accept, classify, then write at once or scan rows, multiply, divide and write.
   tlut_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: ROM lookups, gap product, bit-serial divider and the output register,
   // which holds a finished result while the next transaction is taken in.
   tlut_dpath #(
      .ROWS (ROWS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_raw_sample    (req_raw_sample),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_temp_centideg (rsp_temp_centideg),
      .rsp_temp_valid    (rsp_temp_valid)
   );

   // Once a transaction is taken, hold off the next until this one is written.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // Never overwrite a result that is still waiting to be taken.
   `ASSERT_IMPLIES(a_write_free, clock, reset, cmd.write_rsp, status.rsp_free)
   // A shorted sensor reads zero.
   `ASSERT_IMPLIES(a_short_zero, clock, reset, rsp_valid && !rsp_temp_valid,
      rsp_temp_centideg == '0)
   // A valid reading stays within the table's temperature span.
   `ASSERT_IMPLIES(a_temp_span, clock, reset, rsp_valid && rsp_temp_valid,
      (rsp_temp_centideg >= -15'sd2500) && (rsp_temp_centideg <= 15'sd14000))

endmodule
